// File: hw/rtl/sha256_stream_hasher_top_defines.svh
// Assertion macros used by the top-level RTL file of the stream hasher.
`ifndef SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_STREAM_HASHER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/shs_pkg.sv
package shs_pkg;

    typedef logic [31:0] word_t;

    // Element 0 is working variable a, element 7 is h.
    typedef word_t [7:0] hash_t;

    function automatic hash_t init_hash();
        hash_t h;
        h[0] = 32'h6a09e667;
        h[1] = 32'hbb67ae85;
        h[2] = 32'h3c6ef372;
        h[3] = 32'ha54ff53a;
        h[4] = 32'h510e527f;
        h[5] = 32'h9b05688c;
        h[6] = 32'h1f83d9ab;
        h[7] = 32'h5be0cd19;
        return h;
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

// File: hw/rtl/shs_round.sv
module shs_round
    import shs_pkg::*;
(
    input  hash_t work,
    input  word_t w_cur,
    input  word_t w_1,
    input  word_t w_9,
    input  word_t w_14,
    input  word_t k_const,
    output hash_t work_next,
    output word_t w_new
);

    function automatic word_t big_sigma0(input word_t v);
        return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t v);
        return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t v);
        return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t v);
        return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'b0, v[31:10]};
    endfunction

    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    assign ch  = (work[4] & work[5]) ^ (~work[4] & work[6]);
    assign maj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    assign t1  = work[7] + big_sigma1(work[4]) + ch + k_const + w_cur;
    assign t2  = big_sigma0(work[0]) + maj;

    always_comb
    begin
        work_next[0] = t1 + t2;
        work_next[1] = work[0];
        work_next[2] = work[1];
        work_next[3] = work[2];
        work_next[4] = work[3] + t1;
        work_next[5] = work[4];
        work_next[6] = work[5];
        work_next[7] = work[6];
    end

    // Schedule word sixteen rounds ahead of the current one.
    assign w_new = small_sigma1(w_14) + w_9 + small_sigma0(w_1) + w_cur;

endmodule

// File: hw/rtl/sha256_stream_hasher_top.sv
// SHA-256 over a byte stream.
// Input channel s_axis: tdata carries one message byte, tuser says whether that
// byte belongs to the message, and tlast closes the message. An item with tuser
// low and tlast high closes the message as it stands (empty message included).
// Output channel m_axis: four transactions per closed message, each a 64-bit
// big-endian slice of the digest; tuser gives its position 0..3 and tlast marks
// the fourth.
// A byte that does not fill the 64-byte block is written to the block buffer.
// The byte that fills it starts a compression: 64 rounds on the shared round
// unit, one per cycle, then the chaining add, and tready stays low meanwhile.
// A closing item adds one padding step and one compression, or two of each
// when more than 55 bytes of the last block are in use.
// The digest is then held on m_axis until the receiver takes all four words;
// a stall on m_axis holds the block, and no new input is taken until the last
// word leaves. After that the hash state is back at its initial values.
// Reset restores the initial hash values and clears the byte and length counts.
`include "sha256_stream_hasher_top_defines.svh"

module sha256_stream_hasher_top
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_FINAL = 5'b00100,
        ST_PAD   = 5'b01000,
        ST_OUT   = 5'b10000
    } seq_state_t;

    seq_state_t  state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] len_reg, len_next;
    logic        close_reg, close_next;
    logic        mark_reg, mark_next;
    logic        final_reg, final_next;
    logic [1:0]  out_idx_reg, out_idx_next;
    hash_t       chain_reg, chain_next;
    hash_t       work_reg, work_next;
    word_t       win_reg [16];
    word_t       win_next [16];

    hash_t       round_work;
    word_t       w_new;
    logic        s_accept;
    logic        m_accept;
    logic        len_fits;
    logic [63:0] bit_len;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign m_accept = m_axis_tvalid && m_axis_tready;
    assign bit_len  = {len_reg, 3'b000};
    // Length goes into this block if the end mark was placed in an earlier block
    // or if the mark lands at byte 55 or below.
    assign len_fits = mark_reg || (fill_reg < 6'd56);

    shs_round u_round (
        .work      (work_reg),
        .w_cur     (win_reg[0]),
        .w_1       (win_reg[1]),
        .w_9       (win_reg[9]),
        .w_14      (win_reg[14]),
        .k_const   (round_k(round_reg)),
        .work_next (round_work),
        .w_new     (w_new)
    );

    always_comb
    begin
        state_next   = state_reg;
        round_next   = round_reg;
        fill_next    = fill_reg;
        len_next     = len_reg;
        close_next   = close_reg;
        mark_next    = mark_reg;
        final_next   = final_reg;
        out_idx_next = out_idx_reg;
        chain_next   = chain_reg;
        work_next    = work_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (s_axis_tuser)
                    begin
                        fill_next = fill_reg + 6'd1;
                        len_next  = len_reg + 61'd1;
                    end
                    if (s_axis_tlast)
                    begin
                        close_next = 1'b1;
                    end
                    if (s_axis_tuser && (fill_reg == 6'd63))
                    begin
                        state_next = ST_ROUND;
                        round_next = '0;
                        work_next  = chain_reg;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                work_next  = round_work;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                for (int j = 0; j < 8; j++)
                begin
                    chain_next[j] = chain_reg[j] + work_reg[j];
                end
                if (!close_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (final_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                mark_next  = 1'b1;
                final_next = len_fits;
                state_next = ST_ROUND;
                round_next = '0;
                work_next  = chain_reg;
            end
            ST_OUT:
            begin
                if (m_accept)
                begin
                    out_idx_next = out_idx_reg + 2'd1;
                    if (out_idx_reg == 2'd3)
                    begin
                        chain_next = init_hash();
                        fill_next  = '0;
                        len_next   = '0;
                        close_next = 1'b0;
                        mark_next  = 1'b0;
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Block buffer, held as sixteen big-endian words that double as the
    // message schedule window during the rounds.
    always_comb
    begin
        logic [5:0] pos;
        logic [7:0] old_byte;
        for (int j = 0; j < 16; j++)
        begin
            win_next[j] = win_reg[j];
        end
        pos      = '0;
        old_byte = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && s_axis_tuser)
                begin
                    win_next[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] = s_axis_tdata;
                end
            end
            ST_ROUND:
            begin
                for (int j = 0; j < 15; j++)
                begin
                    win_next[j] = win_reg[j + 1];
                end
                win_next[15] = w_new;
            end
            ST_PAD:
            begin
                for (int j = 0; j < 16; j++)
                begin
                    for (int b = 0; b < 4; b++)
                    begin
                        pos      = 6'(j * 4 + b);
                        old_byte = win_reg[j][(3 - b) * 8 +: 8];
                        if (mark_reg || (pos > fill_reg))
                        begin
                            win_next[j][(3 - b) * 8 +: 8] = 8'h00;
                        end
                        else if (pos == fill_reg)
                        begin
                            win_next[j][(3 - b) * 8 +: 8] = 8'h80;
                        end
                        else
                        begin
                            win_next[j][(3 - b) * 8 +: 8] = old_byte;
                        end
                    end
                end
                if (len_fits)
                begin
                    win_next[14] = bit_len[63:32];
                    win_next[15] = bit_len[31:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            round_reg   <= '0;
            fill_reg    <= '0;
            len_reg     <= '0;
            close_reg   <= 1'b0;
            mark_reg    <= 1'b0;
            final_reg   <= 1'b0;
            out_idx_reg <= '0;
            chain_reg   <= init_hash();
        end
        else
        begin
            state_reg   <= state_next;
            round_reg   <= round_next;
            fill_reg    <= fill_next;
            len_reg     <= len_next;
            close_reg   <= close_next;
            mark_reg    <= mark_next;
            final_reg   <= final_next;
            out_idx_reg <= out_idx_next;
            chain_reg   <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        for (int j = 0; j < 16; j++)
        begin
            win_reg[j] <= win_next[j];
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {chain_reg[{out_idx_reg, 1'b0}], chain_reg[{out_idx_reg, 1'b1}]};
    assign m_axis_tuser  = out_idx_reg;
    assign m_axis_tlast  = (out_idx_reg == 2'd3);

    `SHS_ASSERT_SAME(a_no_overlap, clk, rst_n, s_axis_tready, !m_axis_tvalid, "input and output both open")
    `SHS_ASSERT_NEXT(a_round_end, clk, rst_n, state_reg == ST_ROUND && round_reg == 6'd63, state_reg == ST_FINAL, "compression did not end after round 63")
    `SHS_ASSERT_NEXT(a_block_full, clk, rst_n, s_accept && s_axis_tuser && fill_reg == 6'd63, state_reg == ST_ROUND && round_reg == 6'd0 && fill_reg == 6'd0, "full block did not start compression")
    `SHS_ASSERT_NEXT(a_restart, clk, rst_n, m_accept && m_axis_tlast, state_reg == ST_IDLE && fill_reg == 6'd0 && len_reg == 61'd0 && !close_reg && !mark_reg, "state not restarted after digest")

endmodule
